FILE: design/i2c_master_register_interface_macros.svh
// ----------------------------------------------------------------------------
// I2C master register interface assertion macros
// Shared helpers for the concurrent checks of the register block.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_INTERFACE_MACROS_SVH
`define I2C_MASTER_REGISTER_INTERFACE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define I2CMRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define I2CMRI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/i2cmri_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register interface package
// Register offsets, bit positions, bus command codes and transaction types.
// ----------------------------------------------------------------------------
package i2cmri_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [7:0] OFS_CONTROL   = 8'h00;
  localparam logic [7:0] OFS_STATUS    = 8'h04;
  localparam logic [7:0] OFS_OWNADDR   = 8'h08;
  localparam logic [7:0] OFS_DATA      = 8'h0c;
  localparam logic [7:0] OFS_READY     = 8'h10;
  localparam logic [7:0] OFS_SCRATCH_A = 8'h14;
  localparam logic [7:0] OFS_SCRATCH_B = 8'h18;
  localparam logic [7:0] OFS_SCRATCH_C = 8'h1c;
  localparam logic [7:0] OFS_STATUS2   = 8'h20;

  localparam int STATUS_MODE_LSB  = 6;
  localparam int STATUS_START_BIT = 5;
  localparam int STATUS_NACK_BIT  = 0;
  localparam int STA2_BYTE_BIT    = 8;
  localparam int STA2_STOP_BIT    = 13;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RECEIVE = 3'd3,
    ACT_STOP    = 3'd4
  } action_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic        target_nacked;
    logic [7:0]  received_byte;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    action_t     bus_action;
    logic [6:0]  bus_address;
    logic        bus_read_direction;
    logic [7:0]  bus_send_byte;
    logic        bad_offset;
  } rsp_t;

endpackage

FILE: design/i2cmri_channels.sv
// ----------------------------------------------------------------------------
// I2C master register interface channels
// Valid/ready channels for register accesses and their results.
// ----------------------------------------------------------------------------
interface i2cmri_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  offset;
  logic [31:0] write_data;
  logic        target_nacked;
  logic [7:0]  received_byte;

  modport source (
    output valid, operation, offset, write_data, target_nacked, received_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, offset, write_data, target_nacked, received_byte,
    output ready
  );
endinterface

interface i2cmri_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  bus_action;
  logic [6:0]  bus_address;
  logic        bus_read_direction;
  logic [7:0]  bus_send_byte;
  logic        bad_offset;

  modport source (
    output valid, read_data, bus_action, bus_address, bus_read_direction,
           bus_send_byte, bad_offset,
    input  ready
  );
  modport sink (
    input  valid, read_data, bus_action, bus_address, bus_read_direction,
           bus_send_byte, bad_offset,
    output ready
  );
endinterface

FILE: design/i2cmri_in_stage.sv
// ----------------------------------------------------------------------------
// I2C master register interface input stage
// Registers one incoming access and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module i2cmri_in_stage (
  input  logic             clk,
  input  logic             rst,
  i2cmri_req_if.sink       req,
  input  logic             drain,
  output logic             valid,
  output i2cmri_pkg::req_t item
);
  import i2cmri_pkg::*;

  logic accept;

  assign req.ready = !valid || drain;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.operation     <= req.operation;
      item.offset        <= req.offset;
      item.write_data    <= req.write_data;
      item.target_nacked <= req.target_nacked;
      item.received_byte <= req.received_byte;
    end
  end
endmodule

FILE: design/i2cmri_core.sv
// ----------------------------------------------------------------------------
// I2C master register interface core
// Register file, bus command decode and read multiplexer for one access.
// ----------------------------------------------------------------------------
`include "i2c_master_register_interface_macros.svh"

module i2cmri_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  i2cmri_pkg::req_t item,
  output i2cmri_pkg::rsp_t result
);
  import i2cmri_pkg::*;

  logic [31:0] control_value, control_value_next;
  logic [1:0]  mode_bits, mode_bits_next;
  logic [31:0] own_address_value, own_address_value_next;
  logic [7:0]  data_byte, data_byte_next;
  logic        byte_done_flag, byte_done_flag_next;
  logic        stop_seen_flag, stop_seen_flag_next;
  logic        transfer_busy, transfer_busy_next;
  logic        last_nacked, last_nacked_next;
  logic        receiving, receiving_next;
  logic        data_pending, data_pending_next;

  always_comb begin
    control_value_next     = control_value;
    mode_bits_next         = mode_bits;
    own_address_value_next = own_address_value;
    data_byte_next         = data_byte;
    byte_done_flag_next    = byte_done_flag;
    stop_seen_flag_next    = stop_seen_flag;
    transfer_busy_next     = transfer_busy;
    last_nacked_next       = last_nacked;
    receiving_next         = receiving;
    data_pending_next      = data_pending;
    result                 = '0;
    result.bus_action      = ACT_NONE;

    if (item.operation == OP_READ) begin
      case (item.offset)
        OFS_CONTROL: begin
          result.read_data = control_value;
        end
        OFS_STATUS: begin
          result.read_data[STATUS_MODE_LSB +: 2] = mode_bits;
          result.read_data[STATUS_START_BIT]     = transfer_busy;
          result.read_data[STATUS_NACK_BIT]      = last_nacked;
        end
        OFS_OWNADDR: begin
          result.read_data = own_address_value;
        end
        OFS_DATA: begin
          result.read_data[7:0] = data_byte;
        end
        OFS_READY: begin
          result.read_data = '0;
        end
        OFS_STATUS2: begin
          result.read_data[STA2_BYTE_BIT] = byte_done_flag;
          result.read_data[STA2_STOP_BIT] = stop_seen_flag;
        end
        default: begin
          result.bad_offset = 1'b1;
        end
      endcase
    end else begin
      case (item.offset)
        OFS_CONTROL: begin
          control_value_next = item.write_data;
          if (transfer_busy) begin
            if (receiving) begin
              data_byte_next      = item.received_byte;
              byte_done_flag_next = 1'b1;
              result.bus_action   = ACT_RECEIVE;
            end else if (data_pending) begin
              result.bus_send_byte = data_byte;
              last_nacked_next     = item.target_nacked;
              data_pending_next    = 1'b0;
              byte_done_flag_next  = 1'b1;
              result.bus_action    = ACT_SEND;
            end
          end
        end
        OFS_STATUS: begin
          mode_bits_next = item.write_data[STATUS_MODE_LSB +: 2];
          if (item.write_data[STATUS_START_BIT]) begin
            receiving_next            = data_byte[0];
            result.bus_address        = data_byte[7:1];
            result.bus_read_direction = data_byte[0];
            last_nacked_next          = item.target_nacked;
            transfer_busy_next        = 1'b1;
            data_pending_next         = 1'b0;
            byte_done_flag_next       = 1'b1;
            result.bus_action         = ACT_START;
          end else if (transfer_busy) begin
            transfer_busy_next  = 1'b0;
            stop_seen_flag_next = 1'b1;
            result.bus_action   = ACT_STOP;
          end
        end
        OFS_OWNADDR: begin
          own_address_value_next = item.write_data;
        end
        OFS_DATA: begin
          data_byte_next    = item.write_data[7:0];
          data_pending_next = 1'b1;
        end
        OFS_STATUS2: begin
          if (item.write_data[STA2_BYTE_BIT]) begin
            byte_done_flag_next = 1'b0;
          end
          if (item.write_data[STA2_STOP_BIT]) begin
            stop_seen_flag_next = 1'b0;
          end
        end
        OFS_READY, OFS_SCRATCH_A, OFS_SCRATCH_B, OFS_SCRATCH_C: begin
          result.bad_offset = 1'b0;
        end
        default: begin
          result.bad_offset = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_value     <= '0;
      mode_bits         <= '0;
      own_address_value <= '0;
      data_byte         <= '0;
      byte_done_flag    <= 1'b0;
      stop_seen_flag    <= 1'b0;
      transfer_busy     <= 1'b0;
      last_nacked       <= 1'b0;
      receiving         <= 1'b0;
      data_pending      <= 1'b0;
    end else if (step) begin
      control_value     <= control_value_next;
      mode_bits         <= mode_bits_next;
      own_address_value <= own_address_value_next;
      data_byte         <= data_byte_next;
      byte_done_flag    <= byte_done_flag_next;
      stop_seen_flag    <= stop_seen_flag_next;
      transfer_busy     <= transfer_busy_next;
      last_nacked       <= last_nacked_next;
      receiving         <= receiving_next;
      data_pending      <= data_pending_next;
    end
  end

  `I2CMRI_ASSERT_NEXT(a_start_sets_busy, step && result.bus_action == ACT_START, transfer_busy && byte_done_flag, "START did not leave the transfer busy.")
  `I2CMRI_ASSERT_NEXT(a_stop_clears_busy, step && result.bus_action == ACT_STOP, !transfer_busy && stop_seen_flag, "STOP did not end the transfer.")
  `I2CMRI_ASSERT_NEXT(a_send_consumes_data, step && result.bus_action == ACT_SEND, !data_pending && byte_done_flag, "Send left the data byte pending.")
  `I2CMRI_ASSERT_SAME(a_action_only_on_write, result.bus_action != ACT_NONE, item.operation == OP_WRITE && result.read_data == '0, "Bus command issued by a read transaction.")
endmodule

FILE: design/i2cmri_out_stage.sv
// ----------------------------------------------------------------------------
// I2C master register interface output stage
// Result register that holds a finished transaction until it is taken.
// ----------------------------------------------------------------------------
module i2cmri_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  i2cmri_pkg::rsp_t item,
  output logic             space,
  i2cmri_rsp_if.source     rsp
);
  import i2cmri_pkg::*;

  logic valid;
  rsp_t item_q;

  assign space = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= item;
    end
  end

  assign rsp.valid              = valid;
  assign rsp.read_data          = item_q.read_data;
  assign rsp.bus_action         = item_q.bus_action;
  assign rsp.bus_address        = item_q.bus_address;
  assign rsp.bus_read_direction = item_q.bus_read_direction;
  assign rsp.bus_send_byte      = item_q.bus_send_byte;
  assign rsp.bad_offset         = item_q.bad_offset;
endmodule

FILE: design/i2c_master_register_interface.sv
// ----------------------------------------------------------------------------
// I2C master register interface
// Register side of an I2C master: each transaction on req is one register
// read or write; each produces exactly one result transaction on rsp that
// carries the read data, the bus command issued, and a bad-offset flag.
// The target's acknowledge and received byte travel with the request.
// The path from request acceptance to result valid is one input
// register, then the decode and register update, then the result register.
// Throughput is one transaction per cycle while rsp does not stall; the
// decode between the two registers is combinational.
// When rsp stalls, the result register holds its transaction; the input
// register still accepts one more request, and req.ready drops only when
// both registers are full. Register state advances only when a request
// moves into the result register, so stalls never repeat a bus command.
// Synchronous reset zeroes the register state and empties both stages.
// ----------------------------------------------------------------------------
module i2c_master_register_interface (
  input  logic         clk,
  input  logic         rst,
  i2cmri_req_if.sink   req,
  i2cmri_rsp_if.source rsp
);
  import i2cmri_pkg::*;

  logic in_valid;
  req_t in_item;
  rsp_t core_result;
  logic out_space;
  logic step;

  assign step = in_valid && out_space;

  i2cmri_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .drain (step),
    .valid (in_valid),
    .item  (in_item)
  );

  i2cmri_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (core_result)
  );

  i2cmri_out_stage u_out_stage (
    .clk   (clk),
    .rst   (rst),
    .load  (step),
    .item  (core_result),
    .space (out_space),
    .rsp   (rsp)
  );
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register interface testbench
// Drives register reads and writes into the block, with the target's
// acknowledge and received byte carried in each request. A model of the
// register file and the bus sequencing in this bench predicts every result
// transaction, and a checker compares each one, field by field, against
// the oldest prediction. Directed tests cover the register map, the bad
// offsets and both transfer directions. Random tests then run mostly
// well-formed bus sequences mixed with noise under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cmri_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst;

  i2cmri_req_if req_ch ();
  i2cmri_rsp_if rsp_ch ();

  i2c_master_register_interface uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  int src_idle_pct;
  int sink_idle_pct;
  int accesses_sent;
  int mismatch_count;
  int cycle_count;
  rsp_t pending_results[$];

  logic [31:0] ctrl_reg;
  logic [1:0]  mode_reg;
  logic [31:0] own_addr_reg;
  logic [7:0]  data_reg;
  logic        byte_done;
  logic        stop_seen;
  logic        busy;
  logic        nack_reg;
  logic        rx_mode;
  logic        data_loaded;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic rsp_t i2c_register_access(req_t a);
    rsp_t r;
    r = '0;
    if (a.operation == OP_READ) begin
      case (a.offset)
        OFS_CONTROL: r.read_data = ctrl_reg;
        OFS_STATUS: r.read_data = (32'(mode_reg) << STATUS_MODE_LSB)
                                | (32'(busy) << STATUS_START_BIT)
                                | (32'(nack_reg) << STATUS_NACK_BIT);
        OFS_OWNADDR: r.read_data = own_addr_reg;
        OFS_DATA: r.read_data = 32'(data_reg);
        OFS_READY: r.read_data = '0;
        OFS_STATUS2: r.read_data = (32'(byte_done) << STA2_BYTE_BIT)
                                 | (32'(stop_seen) << STA2_STOP_BIT);
        default: r.bad_offset = 1'b1;
      endcase
    end else begin
      case (a.offset)
        OFS_CONTROL: begin
          ctrl_reg = a.write_data;
          if (busy) begin
            if (rx_mode) begin
              data_reg     = a.received_byte;
              byte_done    = 1'b1;
              r.bus_action = ACT_RECEIVE;
            end else if (data_loaded) begin
              r.bus_send_byte = data_reg;
              nack_reg        = a.target_nacked;
              data_loaded     = 1'b0;
              byte_done       = 1'b1;
              r.bus_action    = ACT_SEND;
            end
          end
        end
        OFS_STATUS: begin
          mode_reg = a.write_data[STATUS_MODE_LSB +: 2];
          if (a.write_data[STATUS_START_BIT]) begin
            rx_mode              = data_reg[0];
            r.bus_address        = data_reg[7:1];
            r.bus_read_direction = data_reg[0];
            nack_reg             = a.target_nacked;
            busy                 = 1'b1;
            data_loaded          = 1'b0;
            byte_done            = 1'b1;
            r.bus_action         = ACT_START;
          end else if (busy) begin
            busy         = 1'b0;
            stop_seen    = 1'b1;
            r.bus_action = ACT_STOP;
          end
        end
        OFS_OWNADDR: own_addr_reg = a.write_data;
        OFS_DATA: begin
          data_reg    = a.write_data[7:0];
          data_loaded = 1'b1;
        end
        OFS_STATUS2: begin
          if (a.write_data[STA2_BYTE_BIT]) byte_done = 1'b0;
          if (a.write_data[STA2_STOP_BIT]) stop_seen = 1'b0;
        end
        OFS_READY, OFS_SCRATCH_A, OFS_SCRATCH_B, OFS_SCRATCH_C: begin
        end
        default: r.bad_offset = 1'b1;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    req_t acc;
    rsp_t got;
    rsp_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.read_data, rsp_ch.bus_action, rsp_ch.bus_address,
               rsp_ch.bus_read_direction, rsp_ch.bus_send_byte, rsp_ch.bad_offset};
        if (pending_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result transaction: data %0h action %0d",
                     got.read_data, got.bus_action);
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data || got.bus_action !== want.bus_action ||
              got.bus_address !== want.bus_address ||
              got.bus_read_direction !== want.bus_read_direction ||
              got.bus_send_byte !== want.bus_send_byte ||
              got.bad_offset !== want.bad_offset) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("mismatch: expected data %0h action %0d addr %0h dir %0b send %0h bad %0b",
                       want.read_data, want.bus_action, want.bus_address,
                       want.bus_read_direction, want.bus_send_byte, want.bad_offset);
              $display("          actual   data %0h action %0d addr %0h dir %0b send %0h bad %0b",
                       got.read_data, got.bus_action, got.bus_address,
                       got.bus_read_direction, got.bus_send_byte, got.bad_offset);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        acc = {req_ch.operation, req_ch.offset, req_ch.write_data,
               req_ch.target_nacked, req_ch.received_byte};
        pending_results.push_back(i2c_register_access(acc));
      end
    end
  end

  function automatic req_t make_access(logic op, logic [7:0] ofs, logic [31:0] wdata,
                                       logic nack, logic [7:0] rx);
    req_t a;
    a.operation     = op;
    a.offset        = ofs;
    a.write_data    = wdata;
    a.target_nacked = nack;
    a.received_byte = rx;
    return a;
  endfunction

  task automatic send_access(req_t a);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= a.operation;
    req_ch.offset        <= a.offset;
    req_ch.write_data    <= a.write_data;
    req_ch.target_nacked <= a.target_nacked;
    req_ch.received_byte <= a.received_byte;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    accesses_sent = accesses_sent + 1;
    @(negedge clk);
  endtask

  task automatic send_rand(logic op, logic [7:0] ofs, logic [31:0] wdata);
    send_access(make_access(op, ofs, wdata, 1'($urandom_range(0, 1)), 8'($urandom)));
  endtask

  task automatic test_register_readback();
    send_access(make_access(OP_WRITE, OFS_CONTROL, 32'hffff_ffff, 1'b1, 8'hff));
    send_access(make_access(OP_READ, OFS_CONTROL, 32'h0, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_OWNADDR, 32'hffff_ffff, 1'b0, 8'h00));
    send_access(make_access(OP_READ, OFS_OWNADDR, 32'hffff_ffff, 1'b1, 8'hff));
    send_access(make_access(OP_WRITE, OFS_READY, 32'hffff_ffff, 1'b0, 8'h00));
    send_access(make_access(OP_READ, OFS_READY, 32'h0, 1'b0, 8'h00));
  endtask

  task automatic test_bad_offsets();
    send_access(make_access(OP_READ, OFS_SCRATCH_A, 32'h0, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_SCRATCH_B, 32'hffff_ffff, 1'b1, 8'hff));
    send_access(make_access(OP_READ, 8'h03, 32'h0, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, 8'hff, 32'hffff_ffff, 1'b1, 8'hff));
  endtask

  task automatic test_write_transfer();
    send_access(make_access(OP_WRITE, OFS_DATA, 32'hffff_ffa4, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS, 32'h0000_00e0, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_CONTROL, 32'h0000_0000, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_DATA, 32'h0000_005a, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_CONTROL, 32'h1234_5678, 1'b1, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS, 32'hffff_ffff, 1'b1, 8'h00));
    send_access(make_access(OP_READ, OFS_STATUS, 32'h0, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS, 32'h0000_0000, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS, 32'h0000_0040, 1'b0, 8'h00));
  endtask

  task automatic test_read_transfer();
    send_access(make_access(OP_WRITE, OFS_DATA, 32'h0000_00ff, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS, 32'h0000_0020, 1'b1, 8'h00));
    send_access(make_access(OP_WRITE, OFS_CONTROL, 32'h0, 1'b1, 8'h00));
    send_access(make_access(OP_WRITE, OFS_CONTROL, 32'h0, 1'b0, 8'hff));
    send_access(make_access(OP_READ, OFS_STATUS2, 32'h0, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS2, 32'h0000_2100, 1'b0, 8'h00));
    send_access(make_access(OP_WRITE, OFS_STATUS, 32'h0000_0000, 1'b0, 8'h00));
  endtask

  task automatic send_side_read();
    logic [7:0] ofs;
    case ($urandom_range(0, 3))
      0: ofs = OFS_STATUS;
      1: ofs = OFS_STATUS2;
      2: ofs = OFS_DATA;
      default: ofs = OFS_CONTROL;
    endcase
    send_rand(OP_READ, ofs, $urandom);
  endtask

  task automatic run_bus_sequence();
    logic       rd;
    logic [6:0] addr;
    int         steps;
    rd   = 1'($urandom_range(0, 1));
    addr = 7'($urandom);
    send_rand(OP_WRITE, OFS_DATA, {24'($urandom), addr, rd});
    send_rand(OP_WRITE, OFS_STATUS, $urandom | (32'h1 << STATUS_START_BIT));
    steps = $urandom_range(1, 6);
    for (int i = 0; i < steps; i++) begin
      if (!rd && $urandom_range(0, 9) < 8)
        send_rand(OP_WRITE, OFS_DATA, $urandom);
      send_rand(OP_WRITE, OFS_CONTROL, $urandom);
      if ($urandom_range(0, 3) == 0) send_side_read();
      if ($urandom_range(0, 5) == 0)
        send_rand(OP_WRITE, OFS_STATUS2, $urandom);
    end
    if ($urandom_range(0, 9) == 0)
      send_rand(OP_WRITE, OFS_STATUS, $urandom | (32'h1 << STATUS_START_BIT));
    if ($urandom_range(0, 99) < 85)
      send_rand(OP_WRITE, OFS_STATUS, $urandom & ~(32'h1 << STATUS_START_BIT));
    if ($urandom_range(0, 1) == 0) send_side_read();
  endtask

  task automatic send_noise();
    logic [7:0] ofs;
    case ($urandom_range(0, 9))
      0: ofs = OFS_CONTROL;
      1: ofs = OFS_STATUS;
      2: ofs = OFS_OWNADDR;
      3: ofs = OFS_DATA;
      4: ofs = OFS_READY;
      5: ofs = OFS_SCRATCH_A + 8'(4 * $urandom_range(0, 2));
      6: ofs = OFS_STATUS2;
      default: ofs = 8'($urandom);
    endcase
    send_rand(1'($urandom_range(0, 1)), ofs, $urandom);
  endtask

  task automatic test_random_traffic(int n_items);
    int start_count;
    start_count = accesses_sent;
    while (accesses_sent - start_count < n_items) begin
      if ($urandom_range(0, 99) < 70) run_bus_sequence();
      else send_noise();
    end
  endtask

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_READ;
    req_ch.offset        = '0;
    req_ch.write_data    = '0;
    req_ch.target_nacked = 1'b0;
    req_ch.received_byte = '0;
    src_idle_pct         = 0;
    sink_idle_pct        = 0;
    accesses_sent        = 0;

    ctrl_reg     = '0;
    mode_reg     = '0;
    own_addr_reg = '0;
    data_reg     = '0;
    byte_done    = 1'b0;
    stop_seen    = 1'b0;
    busy         = 1'b0;
    nack_reg     = 1'b0;
    rx_mode      = 1'b0;
    data_loaded  = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 20;
    sink_idle_pct = 85;
    test_register_readback();
    test_bad_offsets();
    test_write_transfer();
    test_read_transfer();
    test_random_traffic(450);

    src_idle_pct  = 85;
    sink_idle_pct = 20;
    test_random_traffic(450);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(450);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
